@@ hw/rtl/wkct_pkg.sv @@
// shared types and constants for the weighted key count table
`timescale 1ns / 1ps
package wkct_pkg;
   localparam int KEY_BITS   = 64;
   localparam int COUNT_BITS = 16;
   localparam int RND_BITS   = 16;
   localparam int OUT_MOVE_BITS = 16;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_INCR   = 2'd0;
   localparam logic [1:0] STATUS_NEW    = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;
   localparam logic [1:0] STATUS_LOOKUP = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_BUMP,
      ST_MOD,
      ST_WALK,
      ST_DONE
   } state_type;
endpackage

@@ hw/rtl/wkct_ram.sv @@
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module wkct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ hw/rtl/weighted_key_count_table.sv @@
// weighted key count table: records key/move counts and picks weighted moves
//
//   channel | dir | word
//   req_    | in  | tdata = key[63:0], move_code[79:64], random_value[95:80]; tuser = kind
//   rsp_    | out | tdata = chosen_move[15:0], record_status[17:16], zero fill; tuser = found
//
// a record scans the entries (one memory read per entry), then writes back unless the table is full;
// a lookup runs a summing scan and, when more than one entry matches, a 16-step
// restoring modulo, then a walk over the same memory port.
// after reset the counts memory is swept to zero; no word is taken meanwhile.
// a result waits in the output register and holds through stalls;
// the next word is taken no earlier than the edge at which the result leaves.
`timescale 1ns / 1ps
module weighted_key_count_table #(
   parameter int TABLE_DEPTH = 1024,
   parameter int MOVE_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // key, move_code, random_value
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // chosen_move, record_status, zero fill
   output logic        rsp_tuser    // found
);
   import wkct_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int UW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = COUNT_BITS + UW;
   localparam int EW = KEY_BITS + MOVE_BITS;

   state_type state_ff, state_in;
   logic [UW-1:0] used_ff, used_in, idx_ff, idx_in;
   logic [AW-1:0] hit_ff, hit_in;
   logic kind_ff, kind_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [MOVE_BITS-1:0] mv_ff, mv_in;
   logic [RND_BITS-1:0] rnd_ff, rnd_in;
   logic [SW-1:0] total_ff, total_in, n_ff, n_in;
   logic [UW-1:0] matches_ff, matches_in;
   logic [MOVE_BITS-1:0] last_ff, last_in;
   logic [4:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in, found_ff, found_in;
   logic [OUT_MOVE_BITS-1:0] omove_ff, omove_in;
   logic [1:0] status_ff, status_in;

   logic e_we, c_we;
   logic [AW-1:0] e_wa, c_wa, rd_a;
   logic [EW-1:0] e_wd, e_rd;
   logic [COUNT_BITS-1:0] c_wd, c_rd;

   wkct_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry (
      .clock, .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd), .rd_addr(rd_a), .rd_data(e_rd));
   wkct_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_count (
      .clock, .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd), .rd_addr(rd_a), .rd_data(c_rd));

   // entry under test arrives the cycle after its address
   logic [UW-1:0] pidx;
   logic [KEY_BITS-1:0] r_key;
   logic [MOVE_BITS-1:0] r_mv;
   logic key_hit, rec_hit, last_one, req_fire;
   logic [SW-1:0] rem_sh, cnt_w;
   assign r_key = e_rd[EW-1:MOVE_BITS];
   assign r_mv  = e_rd[MOVE_BITS-1:0];
   assign key_hit = (r_key == key_ff);
   assign rec_hit = key_hit && (r_mv == mv_ff);
   assign pidx = idx_ff - UW'(1);
   assign last_one = (idx_ff == used_ff);
   assign cnt_w = SW'(c_rd);
   assign rem_sh = {n_ff[SW-2:0], rnd_ff[RND_BITS-1]};

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = {6'd0, status_ff, omove_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (idx_ff == UW'(TABLE_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE: if (req_fire) state_in = (used_ff == '0) ?
                     (req_tuser == KIND_RECORD ? ST_APPEND : ST_DONE) : ST_SCAN;
         ST_SCAN: begin
            if (kind_ff == KIND_RECORD) begin
               if (rec_hit) state_in = ST_BUMP;
               else if (last_one)
                  state_in = (used_ff == UW'(TABLE_DEPTH)) ? ST_DONE : ST_APPEND;
            end else if (last_one) begin
               state_in = (matches_in > UW'(1)) ? ST_MOD : ST_DONE;
            end
         end
         ST_APPEND: state_in = ST_DONE;
         ST_BUMP:   state_in = ST_DONE;
         ST_MOD:    if (step_ff == 5'(RND_BITS)) state_in = ST_WALK;
         ST_WALK: begin
            if (idx_ff != '0 && key_hit && n_ff <= cnt_w) state_in = ST_DONE;
            else if (idx_ff != '0 && last_one) state_in = ST_DONE;
         end
         ST_DONE: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      used_in = used_ff; idx_in = idx_ff; hit_in = hit_ff;
      kind_in = kind_ff; key_in = key_ff; mv_in = mv_ff; rnd_in = rnd_ff;
      total_in = total_ff; n_in = n_ff; matches_in = matches_ff; last_in = last_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in = found_ff; omove_in = omove_ff; status_in = status_ff;
      e_we = 1'b0; e_wa = hit_ff; e_wd = {key_ff, mv_ff};
      c_we = 1'b0; c_wa = hit_ff; c_wd = '0;
      rd_a = AW'(idx_ff);
      case (state_ff)
         ST_CLEAR: begin
            c_we = 1'b1; c_wa = AW'(idx_ff);
            idx_in = (idx_ff == UW'(TABLE_DEPTH - 1)) ? '0 : idx_ff + UW'(1);
         end
         ST_IDLE: begin
            rd_a = '0;
            if (req_fire) begin
               kind_in = req_tuser;
               key_in = req_tdata[63:0];
               mv_in = MOVE_BITS'(req_tdata[79:64]);
               rnd_in = req_tdata[95:80];
               idx_in = UW'(1);
               total_in = '0; matches_in = '0; last_in = '0;
               found_in = 1'b0; omove_in = '0;
               status_in = (req_tuser == KIND_RECORD) ? STATUS_NEW : STATUS_LOOKUP;
               hit_in = AW'(used_ff);
            end
         end
         ST_SCAN: begin
            if (kind_ff == KIND_RECORD) begin
               if (rec_hit) begin
                  hit_in = AW'(pidx); status_in = STATUS_INCR;
               end else if (last_one && used_ff == UW'(TABLE_DEPTH))
                  status_in = STATUS_FULL;
            end else if (key_hit) begin
               matches_in = matches_ff + UW'(1);
               total_in = total_ff + cnt_w;
               last_in = r_mv;
            end
            if (!last_one) idx_in = idx_ff + UW'(1);
            rd_a = AW'(idx_ff);
            if (kind_ff == KIND_LOOKUP && last_one) begin
               if (matches_in == UW'(1)) begin
                  found_in = 1'b1; omove_in = OUT_MOVE_BITS'(last_in);
               end
               n_in = '0; step_in = '0;
            end
         end
         ST_APPEND: begin
            e_we = 1'b1; c_we = 1'b1; c_wd = COUNT_BITS'(1);
            used_in = used_ff + UW'(1);
         end
         ST_BUMP: begin
            // count was read again at the hit address in the cycle before
            c_we = 1'b1;
            c_wd = (c_rd == '1) ? c_rd : c_rd + COUNT_BITS'(1);
         end
         ST_MOD: begin
            rd_a = AW'(hit_ff);
            if (step_ff != 5'(RND_BITS)) begin
               // restoring division, one quotient bit a step
               n_in = (rem_sh >= total_ff) ? rem_sh - total_ff : rem_sh;
               rnd_in = {rnd_ff[RND_BITS-2:0], 1'b0};
               step_in = step_ff + 5'd1;
            end else begin
               idx_in = UW'(1); rd_a = '0;
            end
         end
         ST_WALK: begin
            rd_a = AW'(idx_ff);
            if (idx_ff != '0 && key_hit) begin
               if (n_ff <= cnt_w) begin
                  found_in = 1'b1; omove_in = OUT_MOVE_BITS'(r_mv);
               end else n_in = n_ff - cnt_w;
            end
            if (!last_one) idx_in = idx_ff + UW'(1);
         end
         ST_DONE: if (!rsp_valid_ff || rsp_tready) rsp_valid_in = 1'b1;
         default: ;
      endcase
      // bump needs the hit count on the read port the cycle before
      if (state_ff == ST_SCAN && kind_ff == KIND_RECORD && rec_hit) rd_a = AW'(pidx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         used_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff <= hit_in; kind_ff <= kind_in; key_ff <= key_in; mv_ff <= mv_in;
      rnd_ff <= rnd_in; total_ff <= total_in; n_ff <= n_in; matches_ff <= matches_in;
      last_ff <= last_in; step_ff <= step_in; found_ff <= found_in;
      omove_ff <= omove_in; status_ff <= status_in;
   end
endmodule
